FILE: design/quaternion_to_euler_defines.svh
// Assertion macros used by the checker file.
`ifndef QUATERNION_TO_EULER_DEFINES_SVH
`define QUATERNION_TO_EULER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define Q2E_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define Q2E_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/q2e_pkg.sv
package q2e_pkg;

  // Working width of the CORDIC datapath (operands normalized below 2^31).
  localparam int unsigned CordW = 34;
  // Angle accumulator width: 2^-22 degree units, 90 degrees fits in 29 bits.
  localparam int unsigned ZW = 32;
  localparam int unsigned TabLen = 32;
  localparam logic [ZW-1:0] Deg90Z = 32'd377487360;

  localparam logic [ZW-1:0] AtanTab [TabLen] = '{
    32'd188743680, 32'd111421900, 32'd58872272, 32'd29884485, 32'd15000234,
    32'd7507429, 32'd3754631, 32'd1877430, 32'd938729, 32'd469366,
    32'd234683, 32'd117342, 32'd58671, 32'd29335, 32'd14668, 32'd7334,
    32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229, 32'd115, 32'd57,
    32'd29, 32'd14, 32'd7, 32'd4, 32'd2, 32'd1, 32'd0, 32'd0, 32'd0
  };

  // Quadrant and sign bookkeeping carried alongside an angle.
  typedef struct packed {
    logic neg_s;
    logic neg_c;
    logic zero;
  } quad_t;

  // One CORDIC lane: x, y, accumulated angle, quadrant info.
  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [ZW:0]      z;
    quad_t                   q;
  } lane_t;

  // Pitch side data.
  typedef struct packed {
    logic neg;
    logic sat;
  } pside_t;

  // Cell bundle: three lanes plus pitch side data.
  typedef struct packed {
    lane_t  roll;
    lane_t  yaw;
    lane_t  pitch;
    pside_t ps;
  } cell_t;

endpackage

FILE: design/q2e_stream_if.sv
interface q2e_stream_if #(
  parameter int unsigned Width = 8
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/quaternion_to_euler.sv
// Quaternion to Euler angle converter. Accepts one quaternion transaction
// per cycle while not stalled and returns one transaction of pitch, yaw and
// roll (1/64 degree) plus a pitch clamp flag. The pipeline is a fixed chain:
// a product stage, a sum stage, a 31-stage square root for the pitch cosine,
// one normalization stage, ANGLE_ITERATIONS CORDIC cells (at most 32) and
// one rounding stage. The whole pipe advances together under a single
// enable that stalls only when the output register is full and not taken,
// so throughput is one transaction per cycle with no gaps unless stalled.
module quaternion_to_euler #(
  parameter int unsigned FRAC_BITS        = 14,
  parameter int unsigned ANGLE_ITERATIONS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  q2e_stream_if.sink   in_i,
  q2e_stream_if.source out_o
);
  // Sum width: holds the exact sums and the constant one at 2*FRAC_BITS.
  localparam int unsigned ProdW = (2 * FRAC_BITS + 4 > 36) ? 2 * FRAC_BITS + 4 : 36;
  localparam int unsigned Lat   = ANGLE_ITERATIONS + 35;
  localparam int unsigned NIt   = (ANGLE_ITERATIONS < q2e_pkg::TabLen)
                                  ? ANGLE_ITERATIONS : q2e_pkg::TabLen;

  logic en;
  logic [Lat-1:0] vld_q;

  // Advance everything when the output slot is free or being drained.
  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_i.valid};
    end
  end

  // Stage 1: products.
  logic signed [15:0] w, x, y, z;
  assign {w, x, y, z} = in_i.data;
  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= w * x; yz_q <= y * z; xx_q <= x * x; yy_q <= y * y;
      wz_q <= w * z; xy_q <= x * y; zz_q <= z * z; wy_q <= w * y;
      zx_q <= z * x;
    end
  end

  // Stage 2: sums.
  localparam logic signed [ProdW-1:0] One = ProdW'(64'sd1 <<< (2 * FRAC_BITS));
  logic signed [ProdW-1:0] sinr_q, cosr_q, siny_q, cosy_q, sinp_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sinr_q <= 2 * (ProdW'(wx_q) + ProdW'(yz_q));
      cosr_q <= One - 2 * (ProdW'(xx_q) + ProdW'(yy_q));
      siny_q <= 2 * (ProdW'(wz_q) + ProdW'(xy_q));
      cosy_q <= One - 2 * (ProdW'(yy_q) + ProdW'(zz_q));
      sinp_q <= 2 * (ProdW'(wy_q) - ProdW'(zx_q));
    end
  end

  // Pitch sine to 30 fraction bits and radicand.
  logic [ProdW-1:0] pa_raw;
  logic [63:0]      pa_sc;
  logic [31:0]      pa;
  logic [61:0]      rad;
  q2e_pkg::pside_t  ps_in;
  always_comb begin
    pa_raw = sinp_q[ProdW-1] ? ProdW'(-sinp_q) : ProdW'(sinp_q);
    ps_in.sat = pa_raw >= ProdW'(One);
    ps_in.neg = sinp_q[ProdW-1];
    if (2 * FRAC_BITS >= 30) pa_sc = 64'(pa_raw) >> (2 * FRAC_BITS - 30);
    else                    pa_sc = 64'(pa_raw) << (30 - 2 * FRAC_BITS);
    pa = ps_in.sat ? 32'd0 : pa_sc[31:0];
    rad = 62'(((64'd1 << 30) - 64'(pa)) * ((64'd1 << 30) + 64'(pa)));
  end

  // Square root delay line; roll/yaw operands ride alongside.
  logic [30:0] root;
  logic [31:0] pa_d;
  q2e_pkg::pside_t ps_d;
  q2e_isqrt u_sqrt (
    .clk_i(clk_i), .en_i(en), .v_i(rad), .a_i(pa), .ps_i(ps_in),
    .root_o(root), .a_o(pa_d), .ps_o(ps_d)
  );

  logic signed [ProdW-1:0] rs_q [31], rc_q [31], ys_q [31], yc_q [31];
  always_ff @(posedge clk_i) begin
    if (en) begin
      rs_q[0] <= sinr_q; rc_q[0] <= cosr_q;
      ys_q[0] <= siny_q; yc_q[0] <= cosy_q;
      for (int i = 1; i < 31; i++) begin
        rs_q[i] <= rs_q[i-1]; rc_q[i] <= rc_q[i-1];
        ys_q[i] <= ys_q[i-1]; yc_q[i] <= yc_q[i-1];
      end
    end
  end

  // Normalization into the first cell.
  q2e_pkg::cell_t c0_d;
  q2e_pkg::cell_t chain [NIt+1];
  q2e_norm #(.InW(ProdW)) u_nr (
    .s_i(rs_q[30][ProdW-1] ? ProdW'(-rs_q[30]) : ProdW'(rs_q[30])),
    .c_i(rc_q[30][ProdW-1] ? ProdW'(-rc_q[30]) : ProdW'(rc_q[30])),
    .neg_s_i(rs_q[30][ProdW-1]), .neg_c_i(rc_q[30][ProdW-1]), .lane_o(c0_d.roll)
  );
  q2e_norm #(.InW(ProdW)) u_ny (
    .s_i(ys_q[30][ProdW-1] ? ProdW'(-ys_q[30]) : ProdW'(ys_q[30])),
    .c_i(yc_q[30][ProdW-1] ? ProdW'(-yc_q[30]) : ProdW'(yc_q[30])),
    .neg_s_i(ys_q[30][ProdW-1]), .neg_c_i(yc_q[30][ProdW-1]), .lane_o(c0_d.yaw)
  );
  q2e_norm #(.InW(ProdW)) u_np (
    .s_i(ProdW'(pa_d)), .c_i(ProdW'(root)),
    .neg_s_i(1'b0), .neg_c_i(1'b0), .lane_o(c0_d.pitch)
  );
  assign c0_d.ps = ps_d;

  always_ff @(posedge clk_i) begin
    if (en) chain[0] <= c0_d;
  end

  for (genvar k = 0; k < NIt; k++) begin : g_cell
    q2e_cell #(.Step(k)) u_cell (
      .clk_i(clk_i), .en_i(en), .d_i(chain[k]), .q_o(chain[k+1])
    );
  end

  // Clamp, round and map quadrants.
  function automatic logic signed [14:0] fin(q2e_pkg::lane_t l);
    logic signed [q2e_pkg::ZW:0] zc;
    logic [q2e_pkg::ZW:0]        zr;
    logic signed [14:0]          a;
    zc = l.z;
    if (zc < 0) zc = '0;
    if (zc > $signed({1'b0, q2e_pkg::Deg90Z})) zc = $signed({1'b0, q2e_pkg::Deg90Z});
    zr = (q2e_pkg::ZW + 1)'(zc) + (q2e_pkg::ZW + 1)'(32768);
    a  = l.q.zero ? 15'sd0 : $signed({2'b00, zr[28:16]});
    if (l.q.neg_c) a = 15'sd11520 - a;
    if (l.q.neg_s) a = -a;
    return a;
  endfunction

  logic signed [14:0] roll_d, yaw_d, pit_a;
  logic signed [13:0] pitch_d;
  q2e_pkg::cell_t last;
  assign last = chain[NIt];
  always_comb begin
    roll_d = fin(last.roll);
    yaw_d  = fin(last.yaw);
    pit_a  = last.ps.sat ? 15'sd5760 : fin(last.pitch);
    pitch_d = last.ps.neg ? 14'(-pit_a) : 14'(pit_a);
  end

  // Output register.
  logic [44:0] out_q;
  always_ff @(posedge clk_i) begin
    if (en) out_q <= {pitch_d, yaw_d, roll_d, last.ps.sat};
  end
  assign out_o.data  = out_q;
  assign out_o.valid = vld_q[Lat-1];
endmodule

FILE: design/q2e_norm.sv
// Fold the magnitudes of an atan2 operand pair into a CORDIC lane start.
module q2e_norm #(
  parameter int unsigned InW = 40
) (
  input  logic [InW-1:0] s_i,
  input  logic [InW-1:0] c_i,
  input  logic           neg_s_i,
  input  logic           neg_c_i,
  output q2e_pkg::lane_t lane_o
);
  localparam int unsigned LzW = $clog2(InW + 1);
  localparam int unsigned SumW = InW + 32;

  logic [InW-1:0]  m;
  logic [LzW-1:0]  msb;
  logic            found;
  logic [SumW-1:0] s_ext;
  logic [SumW-1:0] c_ext;
  logic [SumW-1:0] s_sh;
  logic [SumW-1:0] c_sh;

  assign m = (s_i > c_i) ? s_i : c_i;

  always_comb begin
    msb   = '0;
    found = 1'b0;
    for (int i = InW - 1; i >= 0; i--) begin
      if (!found && m[i]) begin
        msb   = LzW'(i);
        found = 1'b1;
      end
    end
  end

  // Place the leading one at bit 30.
  always_comb begin
    s_ext = SumW'(s_i);
    c_ext = SumW'(c_i);
    if (msb >= LzW'(30)) begin
      s_sh = s_ext >> (msb - LzW'(30));
      c_sh = c_ext >> (msb - LzW'(30));
    end else begin
      s_sh = s_ext << (LzW'(30) - msb);
      c_sh = c_ext << (LzW'(30) - msb);
    end
    lane_o.x      = $signed({2'b00, c_sh[31:0]});
    lane_o.y      = $signed({2'b00, s_sh[31:0]});
    lane_o.z      = '0;
    lane_o.q.neg_s = neg_s_i;
    lane_o.q.neg_c = neg_c_i;
    lane_o.q.zero  = !found;
  end
endmodule

FILE: design/q2e_cell.sv
// One CORDIC vectoring step on three lanes; registered hand-off to the next.
module q2e_cell #(
  parameter int unsigned Step = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  q2e_pkg::cell_t  d_i,
  output q2e_pkg::cell_t  q_o
);
  localparam logic [q2e_pkg::ZW-1:0] Ang = q2e_pkg::AtanTab[Step];

  function automatic q2e_pkg::lane_t rotate(q2e_pkg::lane_t l);
    q2e_pkg::lane_t r;
    logic signed [q2e_pkg::CordW-1:0] dx;
    logic signed [q2e_pkg::CordW-1:0] dy;
    dx = l.y >>> Step;
    dy = l.x >>> Step;
    r  = l;
    if (!l.y[q2e_pkg::CordW-1]) begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + $signed({1'b0, Ang});
    end else begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - $signed({1'b0, Ang});
    end
    return r;
  endfunction

  q2e_pkg::cell_t cell_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q.roll  <= rotate(d_i.roll);
      cell_q.yaw   <= rotate(d_i.yaw);
      cell_q.pitch <= rotate(d_i.pitch);
      cell_q.ps    <= d_i.ps;
    end
  end

  assign q_o = cell_q;
endmodule

FILE: design/q2e_isqrt.sv
// Pipelined integer square root: one result bit per stage, 31 stages.
module q2e_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [61:0] v_i,
  input  logic [31:0] a_i,
  input  q2e_pkg::pside_t ps_i,
  output logic [30:0] root_o,
  output logic [31:0] a_o,
  output q2e_pkg::pside_t ps_o
);
  localparam int unsigned N = 31;

  logic [62:0] rem_q  [N+1];
  logic [30:0] res_q  [N+1];
  logic [31:0] a_q    [N+1];
  q2e_pkg::pside_t ps_q [N+1];

  assign rem_q[0] = {1'b0, v_i};
  assign res_q[0] = '0;
  assign a_q[0]   = a_i;
  assign ps_q[0]  = ps_i;

  for (genvar k = 0; k < N; k++) begin : g_st
    localparam int unsigned B = N - 1 - k;
    logic [62:0] trial;
    logic [62:0] rem_d;
    logic [30:0] res_d;
    logic [62:0] rem_r;
    logic [30:0] res_r;
    logic [31:0] a_r;
    q2e_pkg::pside_t ps_r;
    // Trial: (2*res + 2^B) * 2^B compared with the remainder.
    assign trial = ({32'd0, res_q[k]} << (B + 1)) + (63'd1 << (2 * B));
    always_comb begin
      if (rem_q[k] >= trial) begin
        rem_d = rem_q[k] - trial;
        res_d = res_q[k] | (31'd1 << B);
      end else begin
        rem_d = rem_q[k];
        res_d = res_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_r <= rem_d;
        res_r <= res_d;
        a_r   <= a_q[k];
        ps_r  <= ps_q[k];
      end
    end
    assign rem_q[k+1] = rem_r;
    assign res_q[k+1] = res_r;
    assign a_q[k+1]   = a_r;
    assign ps_q[k+1]  = ps_r;
  end

  assign root_o = res_q[N];
  assign a_o    = a_q[N];
  assign ps_o   = ps_q[N];
endmodule

FILE: design/q2e_checker.sv
`include "quaternion_to_euler_defines.svh"
module q2e_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [44:0] out_data_i
);
  `Q2E_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "output not held")
  `Q2E_ASSERT_IMPL(a_rdy, clk_i, rst_ni, !out_valid_i || out_ready_i, in_ready_i, "input stalled with free output")
  `Q2E_ASSERT_IMPL(a_sat, clk_i, rst_ni, out_valid_i && out_data_i[0], out_data_i[44:31] == 14'd5760 || out_data_i[44:31] == 14'h2980, "saturated pitch not clamped")
  `Q2E_ASSERT_IMPL(a_rng, clk_i, rst_ni, out_valid_i && !out_data_i[44], out_data_i[44:31] <= 14'd5760, "pitch out of range")
endmodule

bind quaternion_to_euler q2e_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready), .out_data_i(out_o.data)
);

FILE: tb/sv/tb_quaternion_to_euler.sv
`timescale 1ns / 100ps

module tb_quaternion_to_euler;

  localparam int unsigned FracBits   = 14;
  localparam int unsigned Iterations = 16;
  // Pipeline depth of the DUT in register stages: ANGLE_ITERATIONS + 35.
  localparam int unsigned Latency    = Iterations + 35;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned NumRandom  = 1700;
  localparam int unsigned NumTail    = 200;
  localparam longint      Deg90Acc   = longint'(90) <<< 22;

  // One result transaction, at the widths of the output port.
  typedef struct packed {
    logic signed [13:0] pitch;
    logic signed [14:0] yaw;
    logic signed [14:0] roll;
    logic               sat;
  } euler_t;

  logic clk_i;
  logic rst_ni;

  q2e_stream_if #(.Width(64)) quat_if ();
  q2e_stream_if #(.Width(45)) euler_if ();

  quaternion_to_euler #(
    .FRAC_BITS       (FracBits),
    .ANGLE_ITERATIONS(Iterations)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (quat_if),
    .out_o (euler_if)
  );

  euler_t      pending_angles[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit          tx_idle_en  = 1'b0;
  bit          rx_idle_en  = 1'b0;
  int unsigned rx_hold     = 0;

  // ---------------------------------------------------------------------
  // Angle predictor
  // ---------------------------------------------------------------------

  // Integer square root, floor, by the bit-pair method.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Vectoring rotation on a first-quadrant vector; angle in 1/64 degree.
  function automatic longint quadrant_angle(longint unsigned sy, longint unsigned cx);
    longint unsigned mag;
    longint          xv;
    longint          yv;
    longint          acc;
    longint          dx;
    longint          dy;
    mag = (sy > cx) ? sy : cx;
    acc = 0;
    if (mag == 0) return 0;
    // Bring the larger operand into [2^30, 2^31); right shifts drop bits.
    while (mag >= (64'd1 << 31)) begin
      mag = mag >> 1; sy = sy >> 1; cx = cx >> 1;
    end
    while (mag < (64'd1 << 30)) begin
      mag = mag << 1; sy = sy << 1; cx = cx << 1;
    end
    xv = longint'(cx);
    yv = longint'(sy);
    for (int i = 0; i < Iterations && i < q2e_pkg::TabLen; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv  = xv + dx; yv = yv - dy; acc = acc + longint'(q2e_pkg::AtanTab[i]);
      end else begin
        xv  = xv - dx; yv = yv + dy; acc = acc - longint'(q2e_pkg::AtanTab[i]);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > Deg90Acc) acc = Deg90Acc;
    return (acc + 32768) >>> 16;
  endfunction

  function automatic longint signed_atan2(longint s, longint c);
    longint ang;
    ang = quadrant_angle((s < 0) ? -s : s, (c < 0) ? -c : c);
    if (c < 0) ang = 11520 - ang;
    if (s < 0) ang = -ang;
    return ang;
  endfunction

  function automatic euler_t predict_angles(logic [63:0] quat);
    longint  w, x, y, z;
    longint  one, sin_p;
    longint unsigned mag, full, cosv;
    longint  pitch;
    euler_t  res;
    {w, x, y, z} = {longint'($signed(quat[63:48])), longint'($signed(quat[47:32])),
                    longint'($signed(quat[31:16])), longint'($signed(quat[15:0]))};
    one   = longint'(1) <<< (2 * FracBits);
    sin_p = 2 * (w * y - z * x);
    res.roll = 15'(signed_atan2(2 * (w * x + y * z), one - 2 * (x * x + y * y)));
    res.yaw  = 15'(signed_atan2(2 * (w * z + x * y), one - 2 * (y * y + z * z)));
    mag = (sin_p < 0) ? -sin_p : sin_p;
    if (mag >= one) begin
      res.sat = 1'b1;
      pitch   = 5760;
    end else begin
      res.sat = 1'b0;
      full = 64'd1 << 30;
      if (2 * FracBits >= 30) mag = mag >> (2 * FracBits - 30);
      else mag = mag << (30 - 2 * FracBits);
      cosv  = floor_sqrt((full - mag) * (full + mag));
      pitch = quadrant_angle(mag, cosv);
    end
    if (sin_p < 0) pitch = -pitch;
    res.pitch = 14'(pitch);
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni         = 1'b0;
    quat_if.valid  = 1'b0;
    quat_if.data   = '0;
    euler_if.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts, plus a long hold when a test asks.
  // ---------------------------------------------------------------------

  initial begin : rx_side
    int unsigned burst;
    burst = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        rx_hold--;
        euler_if.ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        euler_if.ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(0, 18);
        euler_if.ready <= 1'b0;
      end else begin
        euler_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: compare each result transaction with the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin
    euler_t got;
    euler_t want;
    if (rst_ni && euler_if.valid && euler_if.ready) begin
      got = euler_if.data;
      if (pending_angles.size() == 0) begin
        $error("unexpected result transaction %h", got);
        error_count++;
      end else begin
        want = pending_angles.pop_front();
        if (got.pitch !== want.pitch) begin
          $error("pitch_angle: expected %0d, got %0d", want.pitch, got.pitch);
          error_count++;
        end
        if (got.yaw !== want.yaw) begin
          $error("yaw_angle: expected %0d, got %0d", want.yaw, got.yaw);
          error_count++;
        end
        if (got.roll !== want.roll) begin
          $error("roll_angle: expected %0d, got %0d", want.roll, got.roll);
          error_count++;
        end
        if (got.sat !== want.sat) begin
          $error("pitch_saturated: expected %0d, got %0d", want.sat, got.sat);
          error_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if ((quat_if.valid && quat_if.ready) || (euler_if.valid && euler_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("tb_quaternion_to_euler: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------

  // Offer one quaternion and hold it until taken. Valid stays high on
  // return so back-to-back sends never drop it within one step.
  task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
    logic [63:0] quat;
    quat = {w, x, y, z};
    if (tx_idle_en && $urandom_range(0, 9) == 0) begin
      quat_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    quat_if.valid <= 1'b1;
    quat_if.data  <= quat;
    do @(posedge clk_i); while (!quat_if.ready);
    pending_angles.push_back(predict_angles(quat));
  endtask

  task automatic drain_results();
    quat_if.valid <= 1'b0;
    wait (pending_angles.size() == 0);
    @(posedge clk_i);
  endtask

  // Random unit quaternion; sometimes steered near gimbal lock.
  task automatic send_unit_quat();
    real c[4];
    real norm;
    norm = 0.0;
    for (int i = 0; i < 4; i++) begin
      c[i] = real'(int'($urandom_range(0, 65535)) - 32768);
    end
    if ($urandom_range(0, 7) == 0) begin
      c[2] = ($urandom_range(0, 1) ? c[0] : -c[0]) + real'($urandom_range(0, 40)) - 20.0;
      c[1] = c[1] / 200.0;
      c[3] = c[3] / 200.0;
    end
    for (int i = 0; i < 4; i++) norm += c[i] * c[i];
    if (norm < 1.0) norm = 1.0;
    norm = $sqrt(norm);
    send_quat(16'($rtoi(c[0] / norm * 16384.0)), 16'($rtoi(c[1] / norm * 16384.0)),
              16'($rtoi(c[2] / norm * 16384.0)), 16'($rtoi(c[3] / norm * 16384.0)));
  endtask

  task automatic send_mixed_quat();
    if ($urandom_range(0, 4) == 0) begin
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      send_unit_quat();
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Extremes, axis rotations, both sides of the pitch clamp, zero input.
  task automatic test_directed();
    send_quat(16384, 0, 0, 0);
    send_quat(0, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, -16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(0, 0, 0, -16384);
    send_quat(11585, 11585, 0, 0);
    send_quat(11585, 0, 11585, 0);
    send_quat(11586, 0, 11586, 0);
    send_quat(11586, 0, -11586, 0);
    send_quat(11585, 0, -11585, 0);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(-8192, 8192, -8192, 8192);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(-32768, 32767, -32768, 32767);
    send_quat(32767, -32768, 32767, -32768);
    send_quat(0, 0, -32768, 32767);
    send_quat(1, 0, 0, 0);
    send_quat(-1, -1, -1, -1);
    send_quat(-16384, 0, 0, 0);
    drain_results();
  endtask

  // Hold the receiver off long enough to fill the pipe and stall input.
  task automatic test_backpressure();
    rx_hold = 400;
    repeat (150) send_mixed_quat();
    drain_results();
  endtask

  task automatic test_random();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (int i = 0; i < NumRandom; i++) begin
      send_mixed_quat();
      // Pause the sender once until the pipe is empty.
      if (i == NumRandom / 2) drain_results();
    end
  endtask

  // Last stretch at full rate on both sides.
  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (NumTail) send_mixed_quat();
    quat_if.valid <= 1'b0;
  endtask

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    test_full_rate();
    wait (pending_angles.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_quaternion_to_euler: done, clean");
    end else begin
      $display("tb_quaternion_to_euler: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/q2e_pkg.sv
design/q2e_stream_if.sv
design/q2e_norm.sv
design/q2e_cell.sv
design/q2e_isqrt.sv
design/quaternion_to_euler.sv
design/q2e_checker.sv
tb/sv/tb_quaternion_to_euler.sv
